### hw/rtl/assert_macros.svh
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

### hw/rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 6;
  localparam int IDX_W   = 6;   // cell index width for the largest capacity
  localparam int CNT_W   = 7;   // element count width for the largest capacity

  typedef enum logic [3:0] {
    CMD_CLEAR     = 4'd0,
    CMD_INS_FRONT = 4'd1,
    CMD_INS_BACK  = 4'd2,
    CMD_INS_AT    = 4'd3,
    CMD_DEL_FRONT = 4'd4,
    CMD_DEL_BACK  = 4'd5,
    CMD_DEL_AT    = 4'd6,
    CMD_REVERSE   = 4'd7,
    CMD_SORT      = 4'd8,
    CMD_MIDDLE    = 4'd9,
    CMD_SUM       = 4'd10,
    CMD_LIST_FWD  = 4'd11,
    CMD_LIST_REV  = 4'd12
  } cmd_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,   // open a slot at k, write val there
    OP_SHL,   // close the slot at k
    OP_FRT,   // drop the front, write val at k
    OP_OES    // odd-even compare-exchange step
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic [IDX_W-1:0]           k;
    logic [CNT_W-1:0]           n;
    logic                       par;
    logic signed [DATA_W-1:0]   val;
  } cell_ctl_t;

endpackage

### hw/rtl/ple_cell.sv
// One list cell: holds one element and moves it to or from its neighbors.
module ple_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  ple_pkg::cell_ctl_t               ctl,
  input  logic signed [ple_pkg::DATA_W-1:0] left_d,
  input  logic signed [ple_pkg::DATA_W-1:0] right_d,
  output logic signed [ple_pkg::DATA_W-1:0] d
);
  import ple_pkg::*;

  localparam logic [IDX_W-1:0] MY  = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MYC = CNT_W'(IDX);

  logic signed [DATA_W-1:0] d_r, d_nxt;

  always_comb begin
    d_nxt = d_r;
    case (ctl.op)
      OP_SHR: begin
        if (MY > ctl.k) d_nxt = left_d;
        else if (MY == ctl.k) d_nxt = ctl.val;
      end
      OP_SHL: begin
        if (MY >= ctl.k) d_nxt = right_d;
      end
      OP_FRT: begin
        if (MY < ctl.k) d_nxt = right_d;
        else if (MY == ctl.k) d_nxt = ctl.val;
      end
      OP_OES: begin
        // lower cell of a pair keeps the min, upper keeps the max
        if (MY[0] == ctl.par && (MYC + CNT_W'(1)) < ctl.n) begin
          d_nxt = (right_d < d_r) ? right_d : d_r;
        end else if (MY[0] != ctl.par && IDX >= 1 && MYC < ctl.n) begin
          d_nxt = (left_d > d_r) ? left_d : d_r;
        end
      end
      default: d_nxt = d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d = d_r;

endmodule

### hw/rtl/positional_list_engine.sv
// Positional list engine top level: command sequencer over a row of list cells.
//
// Input channel in_valid/in_ready carries one request (command, position, value).
// Output channel out_valid/out_ready carries result items; the final item of a
// request has out_last set. Listing commands give one item per element, all
// others one item.
// How the commands are carried out, with n the element count:
//   clear, insert, delete, unused codes: done on acceptance, result registered.
//   reverse: each front element moved to slot n-1-step; sort: odd-even exchange across the cells.
//   middle, sum, list forward: one rotation of the cell row each.
//   list backward: reverse, rotate out, reverse back.
// Empty lists, and reverse or sort of a single element, finish on acceptance.
// The cell row moves at most one step per cycle.
// A new request is taken once the sequencer is idle and the output register
// is free or being read, even while the previous last result is handed out.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// A stalled receiver (out_ready low) holds the output register; the sequencer
// waits on each item it must emit until the register is free.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [3:0]                         in_command,
  input  logic [ple_pkg::POS_W-1:0]          in_position,
  input  logic signed [ple_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic signed [ple_pkg::DATA_W-1:0]  out_data,
  output logic [ple_pkg::COUNT_W-1:0]        out_count,
  output logic                               out_last
);
  import ple_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {S_IDLE, S_REV, S_SORT, S_SCAN, S_UNREV} state_t;

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           step_r, step_nxt;
  logic signed [DATA_W-1:0] acc_r, acc_nxt;
  logic                    ov_r, ov_nxt;
  logic [1:0]              ost_r, ost_nxt;
  logic signed [DATA_W-1:0] odt_r, odt_nxt;
  logic [COUNT_W-1:0]      ocnt_r, ocnt_nxt;
  logic                    olast_r, olast_nxt;

  cell_ctl_t               ctl;
  logic [IW-1:0]           k;
  logic signed [DATA_W-1:0] cell_d [CAPACITY];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] l_d, r_d;
      if (g == 0) begin : g_l0
        assign l_d = '0;
      end else begin : g_l
        assign l_d = cell_d[g-1];
      end
      if (g == CAPACITY - 1) begin : g_rn
        assign r_d = '0;
      end else begin : g_r
        assign r_d = cell_d[g+1];
      end
      ple_cell #(.IDX(g)) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .left_d (l_d),
        .right_d(r_d),
        .d      (cell_d[g])
      );
    end
  endgenerate

  logic          slot;
  logic          acc_in;
  logic [PW-1:0] pe, ne;
  logic [CW-1:0] last_step;

  assign slot      = !ov_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot;
  assign acc_in    = in_valid && in_ready;
  assign pe        = PW'(in_position);
  assign ne        = PW'(cnt_r);
  assign last_step = cnt_r - CW'(1);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    ov_nxt    = ov_r && !out_ready;
    ost_nxt   = ost_r;
    odt_nxt   = odt_r;
    olast_nxt = olast_r;
    k         = '0;
    ctl.op    = OP_HOLD;
    ctl.par   = step_r[0];
    ctl.val   = cell_d[0];
    ctl.n     = CNT_W'(cnt_r);

    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_OK;
          odt_nxt   = '0;
          olast_nxt = 1'b1;
          cmd_nxt   = cmd_t'(in_command);
          step_nxt  = '0;
          acc_nxt   = '0;
          case (cmd_t'(in_command))
            CMD_CLEAR: cnt_nxt = '0;
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
              if (ne >= PW'(CAPACITY)) begin
                ost_nxt = ST_FULL;
              end else if (cmd_t'(in_command) == CMD_INS_AT &&
                           (pe < PW'(1) || pe > ne + PW'(1))) begin
                ost_nxt = ST_BADPOS;
              end else begin
                if (cmd_t'(in_command) == CMD_INS_FRONT) k = '0;
                else if (cmd_t'(in_command) == CMD_INS_BACK) k = IW'(cnt_r);
                else k = IW'(pe - PW'(1));
                ctl.op  = OP_SHR;
                ctl.val = in_value;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
              if (cnt_r == '0) begin
                ost_nxt = ST_EMPTY;
              end else begin
                k       = (cmd_t'(in_command) == CMD_DEL_FRONT) ? '0 : IW'(last_step);
                ctl.op  = OP_SHL;
                cnt_nxt = last_step;
              end
            end
            CMD_DEL_AT: begin
              if (pe == PW'(1) && cnt_r == '0) begin
                ost_nxt = ST_EMPTY;
              end else if (pe < PW'(1) || pe > ne) begin
                ost_nxt = ST_BADPOS;
              end else begin
                k       = IW'(pe - PW'(1));
                ctl.op  = OP_SHL;
                cnt_nxt = last_step;
              end
            end
            CMD_REVERSE, CMD_SORT: begin
              if (cnt_r >= CW'(2)) begin
                ov_nxt    = 1'b0;
                state_nxt = (cmd_t'(in_command) == CMD_SORT) ? S_SORT : S_REV;
              end
            end
            CMD_MIDDLE, CMD_LIST_FWD, CMD_LIST_REV: begin
              if (cnt_r == '0) begin
                ost_nxt = ST_EMPTY;
              end else begin
                ov_nxt    = 1'b0;
                state_nxt = (cmd_t'(in_command) == CMD_LIST_REV && cnt_r >= CW'(2))
                            ? S_REV : S_SCAN;
              end
            end
            CMD_SUM: begin
              if (cnt_r != '0) begin
                ov_nxt    = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_REV, S_UNREV: begin
        // move the front element to slot n-1-step
        if (step_r != cnt_r - CW'(2) || cmd_r != CMD_REVERSE || slot) begin
          k        = IW'(cnt_r - CW'(1) - step_r);
          ctl.op   = OP_FRT;
          step_nxt = step_r + CW'(1);
          if (step_r == cnt_r - CW'(2)) begin
            step_nxt = '0;
            if (cmd_r == CMD_REVERSE) begin
              ov_nxt    = 1'b1;
              ost_nxt   = ST_OK;
              odt_nxt   = '0;
              olast_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else if (state_r == S_REV) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      S_SORT: begin
        if (step_r != last_step || slot) begin
          ctl.op   = OP_OES;
          step_nxt = step_r + CW'(1);
          if (step_r == last_step) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_OK;
            odt_nxt   = '0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      S_SCAN: begin
        // rotate the row once per cycle while the output slot is free; cell 0 presents each element in turn
        if (slot) begin
          k        = IW'(last_step);
          ctl.op   = OP_FRT;
          step_nxt = step_r + CW'(1);
          if (cmd_r == CMD_SUM) acc_nxt = acc_r + cell_d[0];
          else if (step_r == (cnt_r >> 1)) acc_nxt = cell_d[0];
          if (cmd_r == CMD_LIST_FWD || cmd_r == CMD_LIST_REV) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_OK;
            odt_nxt   = cell_d[0];
            olast_nxt = (step_r == last_step);
          end
          if (step_r == last_step) begin
            step_nxt = '0;
            if (cmd_r == CMD_SUM || cmd_r == CMD_MIDDLE) begin
              ov_nxt    = 1'b1;
              ost_nxt   = ST_OK;
              odt_nxt   = acc_nxt;
              olast_nxt = 1'b1;
            end
            state_nxt = (cmd_r == CMD_LIST_REV && cnt_r >= CW'(2)) ? S_UNREV : S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    ctl.k    = IDX_W'(k);
    ocnt_nxt = COUNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r   <= cmd_nxt;
    acc_r   <= acc_nxt;
    ost_r   <= ost_nxt;
    odt_r   <= odt_nxt;
    olast_r <= olast_nxt;
    if (ov_nxt && slot) ocnt_r <= ocnt_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_data   = odt_r;
  assign out_count  = ocnt_r;
  assign out_last   = olast_r;

  `ASSERT_CLK(a_cnt_cap, cnt_r <= CW'(CAPACITY))
  `ASSERT_CLK(a_req_progress, acc_in |=> (ov_r || state_r != S_IDLE))
  `ASSERT_CLK(a_sort_needs_two, (state_r == S_SORT || state_r == S_REV) |-> cnt_r >= CW'(2))

endmodule
